FILE: src/sparse_polynomial_multiplier_macros.svh
// Assertion macros shared by the sparse polynomial multiplier RTL.
`ifndef SPARSE_POLYNOMIAL_MULTIPLIER_MACROS_SVH
`define SPARSE_POLYNOMIAL_MULTIPLIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/spm_pkg.sv
// Package: widths, opcodes and sequencer states of the sparse polynomial multiplier.
package spm_pkg;

  localparam int MAX_TERMS_DEF    = 32;
  localparam int MAX_EXPONENT_DEF = 31;

  localparam int OP_W      = 2;
  localparam int COEF_W    = 16;
  localparam int EXP_W     = 5;
  localparam int TERM_W    = COEF_W + EXP_W;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int SUM_W     = 48;
  localparam int OUT_EXP_W = 6;
  localparam int EXP_MAX_IN = (1 << EXP_W) - 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_MULTIPLY    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH
  } state_t;

endpackage

FILE: src/spm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spm_ram
  import spm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sparse_polynomial_multiplier.sv
// Top level: sparse polynomial multiplier with term stores and an exponent accumulator.
//
// Requests arrive on in_valid/in_stall with operation, coefficient and exponent.
// Load requests (first or second polynomial) each write one term store; a
// load into a full store, or with exponent above MAX_EXPONENT, is dropped
// and flags loads_dropped for the rest of the run. Operation code 3 is
// ignored. A multiply request walks all term pairs, one pair per cycle through
// a read / multiply / accumulate pipeline on the accumulator RAM, with a
// forwarding register for back-to-back hits on one exponent. The accumulator
// is then scanned, each entry read in ST_SCAN_RD and checked in ST_SCAN_CHK,
// and nonzero sums leave on out_valid/out_stall in ascending exponent order,
// the final one with last_term set; an all-zero product yields one request with
// term_valid low. in_stall stays high throughout a multiply.
// After rst the accumulator is swept to zero, one entry per cycle, with
// in_stall high.
// A stalled result holds in the output register; the scan waits for it.
`include "sparse_polynomial_multiplier_macros.svh"

module sparse_polynomial_multiplier
  import spm_pkg::*;
#(
  parameter int MAX_TERMS    = MAX_TERMS_DEF,
  parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_W-1:0]             operation,
  input  logic signed [COEF_W-1:0]    coefficient,
  input  logic [EXP_W-1:0]            exponent,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SUM_W-1:0]     product_coefficient,
  output logic [OUT_EXP_W-1:0]        product_exponent,
  output logic                        term_valid,
  output logic                        loads_dropped,
  output logic                        last_term
);

  localparam int EFF_EXP   = (MAX_EXPONENT < EXP_MAX_IN) ? MAX_EXPONENT : EXP_MAX_IN;
  localparam int SUM_DEPTH = 2 * EFF_EXP + 1;
  localparam int ACC_AW    = $clog2(SUM_DEPTH);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam logic [ACC_AW-1:0] ACC_LAST = ACC_AW'(SUM_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_TERMS);

  state_t state, state_next;
  logic [CNT_W-1:0] first_count, first_count_next;
  logic [CNT_W-1:0] second_count, second_count_next;
  logic overflow, overflow_next;
  logic [IDX_W-1:0] ja, ja_next;
  logic [IDX_W-1:0] ib, ib_next;
  logic [ACC_AW-1:0] sweep, sweep_next;
  logic v1, v1_next, v2, v3;
  logic [ACC_AW-1:0] e2, e3;
  logic signed [PROD_W-1:0] p2;
  logic [SUM_W-1:0] sum3;
  logic pend_valid, pend_valid_next;
  logic [SUM_W-1:0] pend_coef, pend_coef_next;
  logic [ACC_AW-1:0] pend_exp, pend_exp_next;
  logic out_valid_next, term_valid_next, last_term_next, loads_dropped_next;
  logic [SUM_W-1:0] product_coefficient_next;
  logic [OUT_EXP_W-1:0] product_exponent_next;

  logic we_a, we_b;
  logic [TERM_W-1:0] q_a, q_b;
  logic acc_we;
  logic [ACC_AW-1:0] acc_waddr, acc_raddr;
  logic [SUM_W-1:0] acc_wdata, acc_q, acc_base, acc_sum;
  logic [OUT_EXP_W-1:0] e1;
  logic signed [PROD_W-1:0] p1;
  logic in_accept, slot_free, exp_ok, acc_nz;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign exp_ok    = int'(exponent) <= MAX_EXPONENT;
  assign acc_nz    = (acc_q != '0);

  spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_first_ram (
    .clk(clk), .we(we_a), .waddr(first_count[IDX_W-1:0]),
    .wdata({coefficient, exponent}), .raddr(ja), .rdata(q_a)
  );

  spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_second_ram (
    .clk(clk), .we(we_b), .waddr(second_count[IDX_W-1:0]),
    .wdata({coefficient, exponent}), .raddr(ib), .rdata(q_b)
  );

  spm_ram #(.WIDTH(SUM_W), .DEPTH(SUM_DEPTH)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr),
    .wdata(acc_wdata), .raddr(acc_raddr), .rdata(acc_q)
  );

  // stage 1: term data back from the stores
  assign e1 = {1'b0, q_a[EXP_W-1:0]} + {1'b0, q_b[EXP_W-1:0]};
  assign p1 = $signed(q_a[TERM_W-1:EXP_W]) * $signed(q_b[TERM_W-1:EXP_W]);

  // stage 2: accumulate, forwarding the previous write on an exponent hit
  assign acc_base = (v3 && (e3 == e2)) ? sum3 : acc_q;
  assign acc_sum  = acc_base + {{(SUM_W - PROD_W){p2[PROD_W-1]}}, p2};

  always_comb begin
    state_next               = state;
    first_count_next         = first_count;
    second_count_next        = second_count;
    overflow_next            = overflow;
    ja_next                  = ja;
    ib_next                  = ib;
    sweep_next               = sweep;
    v1_next                  = 1'b0;
    pend_valid_next          = pend_valid;
    pend_coef_next           = pend_coef;
    pend_exp_next            = pend_exp;
    out_valid_next           = out_valid && out_stall;
    product_coefficient_next = product_coefficient;
    product_exponent_next    = product_exponent;
    term_valid_next          = term_valid;
    last_term_next           = last_term;
    loads_dropped_next       = loads_dropped;
    we_a                     = 1'b0;
    we_b                     = 1'b0;
    acc_we                   = v2;
    acc_waddr                = e2;
    acc_wdata                = acc_sum;
    acc_raddr                = ACC_AW'(e1);

    case (state)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = sweep;
        acc_wdata = '0;
        if (sweep == ACC_LAST) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (operation)
            OP_LOAD_FIRST: begin
              if (first_count < CNT_FULL && exp_ok) begin
                we_a             = 1'b1;
                first_count_next = first_count + 1'b1;
              end else begin
                overflow_next = 1'b1;
              end
            end
            OP_LOAD_SECOND: begin
              if (second_count < CNT_FULL && exp_ok) begin
                we_b              = 1'b1;
                second_count_next = second_count + 1'b1;
              end else begin
                overflow_next = 1'b1;
              end
            end
            OP_MULTIPLY: begin
              ja_next = '0;
              ib_next = '0;
              if (first_count != '0 && second_count != '0) begin
                state_next = ST_MUL;
              end else begin
                state_next = ST_FINISH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        v1_next = 1'b1;
        if (CNT_W'(ja) + 1'b1 == first_count) begin
          ja_next = '0;
          if (CNT_W'(ib) + 1'b1 == second_count) begin
            ib_next    = '0;
            state_next = ST_DRAIN;
          end else begin
            ib_next = ib + 1'b1;
          end
        end else begin
          ja_next = ja + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          sweep_next = '0;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        acc_raddr  = sweep;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        acc_raddr = sweep;
        if (!(acc_nz && pend_valid && !slot_free)) begin
          if (acc_nz) begin
            if (pend_valid) begin
              out_valid_next           = 1'b1;
              product_coefficient_next = pend_coef;
              product_exponent_next    = OUT_EXP_W'(pend_exp);
              term_valid_next          = 1'b1;
              last_term_next           = 1'b0;
              loads_dropped_next       = overflow;
            end
            pend_valid_next = 1'b1;
            pend_coef_next  = acc_q;
            pend_exp_next   = sweep;
          end
          acc_we    = 1'b1;
          acc_waddr = sweep;
          acc_wdata = '0;
          if (sweep == ACC_LAST) begin
            sweep_next = '0;
            state_next = ST_FINISH;
          end else begin
            sweep_next = sweep + 1'b1;
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_next           = 1'b1;
          product_coefficient_next = pend_valid ? pend_coef : '0;
          product_exponent_next    = pend_valid ? OUT_EXP_W'(pend_exp) : '0;
          term_valid_next          = pend_valid;
          last_term_next           = 1'b1;
          loads_dropped_next       = overflow;
          pend_valid_next          = 1'b0;
          first_count_next         = '0;
          second_count_next        = '0;
          overflow_next            = 1'b0;
          state_next               = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      first_count  <= '0;
      second_count <= '0;
      overflow     <= 1'b0;
      ja           <= '0;
      ib           <= '0;
      sweep        <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
      overflow     <= overflow_next;
      ja           <= ja_next;
      ib           <= ib_next;
      sweep        <= sweep_next;
      v1           <= v1_next;
      v2           <= v1;
      v3           <= v2;
      pend_valid   <= pend_valid_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    e2                  <= ACC_AW'(e1);
    p2                  <= p1;
    e3                  <= e2;
    sum3                <= acc_sum;
    pend_coef           <= pend_coef_next;
    pend_exp            <= pend_exp_next;
    product_coefficient <= product_coefficient_next;
    product_exponent    <= product_exponent_next;
    term_valid          <= term_valid_next;
    last_term           <= last_term_next;
    loads_dropped       <= loads_dropped_next;
  end

  `SPM_ASSERT_IMPL(a_acc_only_in_mul, clk, rst, v2, (state == ST_MUL || state == ST_DRAIN), "accumulate outside multiply")
  `SPM_ASSERT_IMPL(a_drained_before_scan, clk, rst, (state == ST_SCAN_RD), (!v1 && !v2), "scan before pipeline drained")
  `SPM_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, (first_count <= CNT_FULL && second_count <= CNT_FULL), "term count above capacity")
  `SPM_ASSERT_NEXT(a_finish_last, clk, rst, (state == ST_FINISH && slot_free), (out_valid && last_term && first_count == '0 && state == ST_IDLE), "run end without last result")

endmodule
